### sv/sorted_unique_set_insert_assert.svh
// Assertion macros for the RTL.
`ifndef SORTED_UNIQUE_SET_INSERT_ASSERT_SVH
`define SORTED_UNIQUE_SET_INSERT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SUS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sorted set assertion failed");

// Next-cycle implication, checked out of reset.
`define SUS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sorted set assertion failed");

`endif

### sv/sus_pkg.sv
package sus_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VW = 32;
  localparam int PW = 6;
  localparam int SW = 3;
  localparam int NW = 7;

  localparam logic [SW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [SW-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [SW-1:0] ST_FULL      = 3'd2;
  localparam logic [SW-1:0] ST_READ_OK   = 3'd3;
  localparam logic [SW-1:0] ST_BEYOND    = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } state_t;

  // Broadcast from control to every cell.
  typedef struct packed {
    logic          eval;     // latch per-cell compare results
    logic          shift;    // perform the insert shift
    logic [VW-1:0] value;
    logic [PW-1:0] position;
  } chain_ctrl_t;

  // Reduced answers from the chain.
  typedef struct packed {
    logic          dup;
    logic [VW-1:0] rd_data;
  } chain_res_t;

endpackage

### sv/sus_cell.sv
module sus_cell
  import sus_pkg::*;
(
  input  logic          clk,
  input  chain_ctrl_t   ctrl,
  input  logic          valid,      // this slot is below the held count
  input  logic          rd_sel,     // this slot is the requested read position
  input  logic          lt_left,    // left neighbor holds a smaller value
  input  logic [VW-1:0] entry_left, // left neighbor's entry
  output logic          lt,
  output logic [VW-1:0] entry,
  output logic          eq_hit,
  output logic [VW-1:0] rd_word
);

  assign lt = valid && ($signed(entry) < $signed(ctrl.value));

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      eq_hit  <= valid && (entry == ctrl.value);
      rd_word <= (valid && rd_sel) ? entry : '0;
    end
    // smaller entries stay; the boundary cell takes the new value, the rest shift up
    if (ctrl.shift && !lt) begin
      entry <= lt_left ? ctrl.value : entry_left;
    end
  end

endmodule

### sv/sus_chain.sv
module sus_chain
  import sus_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  chain_ctrl_t   ctrl,
  input  logic [CW-1:0] count,
  output chain_res_t    res
);

  logic          lt_w    [DEPTH];
  logic [VW-1:0] entry_w [DEPTH];
  logic          eq_w    [DEPTH];
  logic [VW-1:0] rd_w    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          valid_i;
    logic          rd_sel_i;
    logic          lt_left_i;
    logic [VW-1:0] entry_left_i;

    assign valid_i  = (32'(i) < 32'(count));
    assign rd_sel_i = (32'(i) == 32'(ctrl.position));

    if (i == 0) begin : g_head
      assign lt_left_i    = 1'b1;
      assign entry_left_i = '0;
    end else begin : g_body
      assign lt_left_i    = lt_w[i-1];
      assign entry_left_i = entry_w[i-1];
    end

    sus_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valid_i),
      .rd_sel     (rd_sel_i),
      .lt_left    (lt_left_i),
      .entry_left (entry_left_i),
      .lt         (lt_w[i]),
      .entry      (entry_w[i]),
      .eq_hit     (eq_w[i]),
      .rd_word    (rd_w[i])
    );
  end

  // OR over registered per-cell flags; at most one cell hits
  always_comb begin
    res.dup     = 1'b0;
    res.rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      res.dup     = res.dup | eq_w[i];
      res.rd_data = res.rd_data | rd_w[i];
    end
  end

endmodule

### sv/sorted_unique_set_insert.sv
// Sorted unique set: a table of up to DEPTH signed 32-bit values kept in
// ascending order with no duplicates, held in a row of compare-and-shift cells.
//
// Input stream (s_*): one request per accepted beat. s_tuser is the mode
// (0 insert value, 1 read entry at position); s_tdata carries value and
// position. Output stream (m_*): exactly one result per request, in order.
// m_tuser is the status (inserted, duplicate, full, read ok, beyond count);
// m_tdata carries the read value (zero unless read ok) and the entry count
// after the request.
//
// Timing: a request passes through accept, per-cell compare into cell
// flags, then reduction and commit (shift and count update) with the result
// landing in the output register. A request is accepted only in the idle
// step, so the next one is not taken until the compare/reduce/commit
// sequence of the last has finished. A new request is taken while the previous
// result is still waiting in the output register.
//
// Stall: if the receiver holds m_tready low, a finished request waits in the
// commit step until the output register frees; the table is not touched
// until then. Reset clears the count and the output valid; the table
// contents are undefined until written, so no clearing pass is needed.
module sorted_unique_set_insert
  import sus_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[37:32], zero fill
  input  logic        s_tuser,   // mode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_value[31:0], entry_count[38:32], zero fill
  output logic [2:0]  m_tuser    // status[2:0]
);

  `include "sorted_unique_set_insert_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;

  // latched request
  logic          req_mode;
  logic [VW-1:0] req_value;
  logic [PW-1:0] req_position;

  logic          s_fire;
  logic          slot_free;
  logic          commit_fire;
  logic          full;
  logic          ins_ok;
  logic [SW-1:0] status_next;

  chain_ctrl_t   ctrl;
  chain_res_t    res;

  assign s_fire    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign full      = (32'(count) >= 32'(DEPTH));

  // result of the request in the commit step
  always_comb begin
    ins_ok = 1'b0;
    if (req_mode == MODE_READ) begin
      status_next = (32'(req_position) < 32'(count)) ? ST_READ_OK : ST_BEYOND;
    end else if (res.dup) begin
      status_next = ST_DUPLICATE;
    end else if (full) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_INSERTED;
      ins_ok      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    commit_fire   = 1'b0;
    count_next    = count;
    ctrl.eval     = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.value    = req_value;
    ctrl.position = req_position;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        ctrl.eval  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          commit_fire = 1'b1;
          ctrl.shift  = ins_ok;
          if (ins_ok) count_next = count + CW'(1);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (commit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_mode     <= s_tuser;
      req_value    <= s_tdata[31:0];
      req_position <= s_tdata[37:32];
    end
    if (commit_fire) begin
      m_tuser        <= status_next;
      m_tdata[31:0]  <= (status_next == ST_READ_OK) ? res.rd_data : '0;
      m_tdata[38:32] <= NW'(count_next);
      m_tdata[39]    <= 1'b0;
    end
  end

  sus_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count),
    .res   (res)
  );

  `SUS_ASSERT_NEXT(a_accept_to_eval, s_fire, state == S_EVAL)
  `SUS_ASSERT_NEXT(a_insert_counts, commit_fire && ins_ok, count == $past(count) + CW'(1))
  `SUS_ASSERT_NEXT(a_other_keeps_count, commit_fire && !ins_ok, count == $past(count))
  `SUS_ASSERT_SAME(a_no_shift_when_full, ctrl.shift, !full && !res.dup)

endmodule

### verif/sorted_unique_set_checker.sv
module sorted_unique_set_checker
  import sus_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[37:32], zero fill
  input  logic        s_tuser,   // mode[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // read_value[31:0], entry_count[38:32], zero fill
  input  logic [2:0]  m_tuser,   // status[2:0]
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SW-1:0] status;
    logic [VW-1:0] read_value;
    logic [NW-1:0] entry_count;
  } outcome_t;

  outcome_t      expected_q[$];
  logic [VW-1:0] set_entries[DEPTH_DEF];
  int            set_size;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  MISMATCH  %s", $time, msg);
    mismatches++;
  endtask

  // Sorted insert / positional read against the local copy of the table.
  task automatic apply_request(input logic mode, input logic [VW-1:0] value,
                               input logic [PW-1:0] position, output outcome_t res);
    int slot;
    int k;
    res.status      = ST_INSERTED;
    res.read_value  = '0;
    slot            = 0;
    if (mode == MODE_INSERT) begin
      while (slot < set_size && $signed(set_entries[slot]) < $signed(value))
        slot++;
      if (slot < set_size && set_entries[slot] == value) begin
        res.status = ST_DUPLICATE;
      end else if (set_size >= DEPTH_DEF) begin
        res.status = ST_FULL;
      end else begin
        for (k = set_size; k > slot; k--)
          set_entries[k] = set_entries[k-1];
        set_entries[slot] = value;
        set_size++;
      end
    end else if (int'(position) < set_size) begin
      res.status     = ST_READ_OK;
      res.read_value = set_entries[position];
    end else begin
      res.status = ST_BEYOND;
    end
    res.entry_count = NW'(set_size);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      set_size   = 0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      // result first: it always belongs to an earlier request
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d data %h",
                                    m_tuser, m_tdata));
        end else begin
          want = expected_q.pop_front();
          if (m_tuser != want.status)
            report_mismatch($sformatf("status got %0d expected %0d", m_tuser, want.status));
          if (m_tdata[31:0] != want.read_value)
            report_mismatch($sformatf("read_value got %h expected %h",
                                      m_tdata[31:0], want.read_value));
          if (m_tdata[38:32] != want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      m_tdata[38:32], want.entry_count));
        end
      end
      if (s_tvalid && s_tready) begin
        apply_request(s_tuser, s_tdata[31:0], s_tdata[37:32], want);
        expected_q.push_back(want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

### verif/tb_sorted_unique_set_insert.sv
module tb_sorted_unique_set_insert;
  import sus_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int TAIL_CYCLES  = 20;      // settling time after drain

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int sent        = 0;

  // Idle shaping: steady flags give stretches with no gaps on that side,
  // rx_hold asks the receiver for one long hold-off.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit rx_hold   = 1'b0;

  // Stimulus-side record of values the table holds (unsorted); the table
  // never shrinks, so this is exact. Used only to aim reads and duplicates.
  logic [31:0] stored_values[$];

  sorted_unique_set_insert dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sorted_unique_set_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, outstanding);
      $display("tb_sorted_unique_set_insert NOT OK");
      $finish;
    end
  end

  function automatic bit is_stored(input logic [31:0] v);
    foreach (stored_values[i])
      if (stored_values[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // Smallest (want_max = 0) or largest stored value, signed order.
  function automatic logic [31:0] extreme_stored(input bit want_max);
    logic [31:0] best;
    best = stored_values[0];
    foreach (stored_values[i])
      if (want_max ? ($signed(stored_values[i]) > $signed(best))
                   : ($signed(stored_values[i]) < $signed(best)))
        best = stored_values[i];
    return best;
  endfunction

  function automatic logic [31:0] pick_stored();
    return stored_values[$urandom_range(0, stored_values.size() - 1)];
  endfunction

  // Candidate for a new entry: full-range random, small values near zero,
  // neighbors of held entries, just below the first entry, or extremes.
  function automatic logic [31:0] fresh_value();
    logic [31:0] v;
    logic [31:0] corner[7];
    corner = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
               32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
    v = $urandom;
    case ($urandom_range(0, 5))
      1: v = $urandom_range(0, 40) - 20;
      2: if (stored_values.size() > 0)
           v = pick_stored() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
      3: if (stored_values.size() > 0)
           v = extreme_stored(1'b0) - $urandom_range(1, 4);
      4: v = corner[$urandom_range(0, 6)];
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] read_position();
    if (stored_values.size() > 0 && $urandom_range(0, 3) != 0)
      return 6'($urandom_range(0, stored_values.size() - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // One request through the input channel. Called and returns at a falling
  // edge; valid stays high across back-to-back requests.
  task automatic send_request(input logic mode, input logic [31:0] value,
                              input logic [5:0] position);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, position, value};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
    if (mode == MODE_INSERT && stored_values.size() < DEPTH_DEF && !is_stored(value))
      stored_values.push_back(value);
  endtask

  // Ignored fields get random content so their bits toggle too.
  task automatic send_insert(input logic [31:0] value);
    send_request(MODE_INSERT, value, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_read(input logic [5:0] position);
    send_request(MODE_READ, $urandom, position);
  endtask

  // Sender stops until every pending result has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Receiver: random hold-off before each result, steady stretches, and one
  // long hold-off counted here.
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold) begin
        wait_cycles = HOLD_CYCLES;
        rx_hold     = 1'b0;
      end else begin
        wait_cycles = rx_steady ? 0 : $urandom_range(0, 17);
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_INSERT;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table reads, first insert, front inserts, duplicates
    // of the first and last entries, both signed extremes, middle inserts,
    // then reads at the edges of the held range and past it.
    send_read(6'd0);
    send_read(6'd63);
    send_insert(32'd0);
    send_insert(32'd0);
    send_insert(32'd100);
    send_insert(-32'sd5);
    send_insert(-32'sd5);
    send_insert(32'h8000_0000);
    send_insert(32'h7FFF_FFFF);
    send_insert(32'd50);
    send_insert(32'h7FFF_FFFF);
    send_insert(32'h8000_0000);
    send_insert(32'hFFFF_FFFF);
    send_insert(32'd1);
    send_read(6'd0);
    send_read(6'd1);
    send_read(6'(stored_values.size() - 1));
    send_read(6'(stored_values.size()));
    send_read(6'd63);
    send_read(6'd32);

    // Pause until empty, then a long receiver hold-off while requests keep
    // coming, so the block backs up and drops s_tready.
    drain();
    rx_hold = 1'b1;

    // Random, table filling slowly: reads, fresh inserts and duplicates.
    for (int i = 0; i < 470; i++) begin
      if (i % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 45)
        send_read(read_position());
      else if ((r < 57 && stored_values.size() < DEPTH_DEF - 4) || stored_values.size() == 0)
        send_insert(fresh_value());
      else
        send_insert(pick_stored());
    end

    // Sender pauses for a full drain, then the table is filled up.
    drain();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    while (stored_values.size() < DEPTH_DEF) begin
      if ($urandom_range(0, 1))
        send_insert(fresh_value());
      else
        send_read(read_position());
    end

    // Full table: refused inserts, duplicates (first and last too), reads.
    send_insert(extreme_stored(1'b0));
    send_insert(extreme_stored(1'b1));
    send_read(6'd63);
    for (int i = 0; i < 150; i++) begin
      if (i % 40 == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_steady = ($urandom_range(0, 2) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 35)
        send_insert(fresh_value());
      else if (r < 65)
        send_insert(pick_stored());
      else
        send_read(6'($urandom_range(0, 63)));
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests: inserts into empty, partial and full table,",
             sent);
    $display("  duplicates, reads in and past range; table ended at %0d entries",
             stored_values.size());
    if (mismatches == 0) begin
      $display("tb_sorted_unique_set_insert OK");
    end else begin
      $display("tb_sorted_unique_set_insert NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sus_pkg.sv
sv/sus_cell.sv
sv/sus_chain.sv
sv/sorted_unique_set_insert.sv
verif/sorted_unique_set_checker.sv
verif/tb_sorted_unique_set_insert.sv
